@@ src/dmxfc_pkg.sv @@
package dmxfc_pkg;

	// default sizes, overridable on the top level
	localparam int CAPTURE_DEPTH_DEF = 1024;
	localparam int FRAME_SLOTS_DEF   = 513;
	localparam int CHANNEL_COUNT_DEF = 512;

	// fixed field widths
	localparam int OP_W   = 2;
	localparam int BYTE_W = 8;
	localparam int CHAN_W = 10;
	localparam int SIZE_W = 10;
	localparam int CNT_W  = 32;
	localparam int TMO_W  = 16;
	localparam int IDX_W  = 1;

	// event codes
	localparam logic [OP_W-1:0] OP_BYTE  = 2'd0;
	localparam logic [OP_W-1:0] OP_BREAK = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
	localparam logic [OP_W-1:0] OP_READ  = 2'd3;

	// register indexes
	localparam logic [IDX_W-1:0] REG_ENABLE  = 1'd0;
	localparam logic [IDX_W-1:0] REG_TIMEOUT = 1'd1;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [BYTE_W-1:0] data_byte;
		logic [CHAN_W-1:0] channel;
	} evt_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_value;
		logic [SIZE_W-1:0] packet_size;
		logic [CNT_W-1:0]  packet_count;
		logic              connected;
	} res_t;

	// status of one event after its state update
	typedef struct packed {
		logic [SIZE_W-1:0] packet_size;
		logic [CNT_W-1:0]  packet_count;
		logic              connected;
		logic              read_ok;
	} stat_t;

endpackage

@@ src/dmxfc_mem.sv @@
module dmxfc_mem import dmxfc_pkg::*; #(
	parameter int AW = 11
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [AW-1:0]     addr,
	input  logic [BYTE_W-1:0] wdata,
	output logic [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem_q [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

@@ src/dmxfc_ctrl.sv @@
module dmxfc_ctrl import dmxfc_pkg::*; #(
	parameter int CAPTURE_DEPTH = CAPTURE_DEPTH_DEF,
	parameter int FRAME_SLOTS   = FRAME_SLOTS_DEF,
	parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
	localparam int CW  = $clog2(CAPTURE_DEPTH),
	localparam int AW  = CW + 1,
	localparam int CCW = $clog2(CAPTURE_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  evt_t              evt,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [TMO_W-1:0]  cfg_data,
	output logic              mem_we,
	output logic              mem_re,
	output logic [AW-1:0]     mem_addr,
	output logic [BYTE_W-1:0] mem_wdata,
	output stat_t             stat
);

	logic              enable_q;
	logic [TMO_W-1:0]  timeout_q;
	logic [CCW-1:0]    cap_count_q, cap_count_d;
	logic              cap_bank_q, cap_bank_d;
	logic              frm_bank_q, frm_bank_d;
	logic              frm_first_q, frm_first_d;
	logic [SIZE_W-1:0] frm_size_q, frm_size_d;
	logic [CNT_W-1:0]  frm_count_q, frm_count_d;
	logic [TMO_W-1:0]  age_q, age_d;
	logic              first;
	logic [CCW-1:0]    len_full;
	logic              link_now;
	logic [CW-1:0]     rd_idx;

	// first byte after a break is an artifact once two or more were seen
	assign first    = cap_count_q >= CCW'(2);
	assign len_full = cap_count_q - CCW'(first);
	assign link_now = enable_q && (age_q < timeout_q);
	assign rd_idx   = CW'(evt.channel) + CW'(frm_first_q);

	always_comb begin
		cap_count_d = cap_count_q;
		cap_bank_d  = cap_bank_q;
		frm_bank_d  = frm_bank_q;
		frm_first_d = frm_first_q;
		frm_size_d  = frm_size_q;
		frm_count_d = frm_count_q;
		age_d       = age_q;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_addr    = {cap_bank_q, cap_count_q[CW-1:0]};
		mem_wdata   = evt.data_byte;
		case (evt.operation)
			OP_BYTE: begin
				if (cap_count_q != CCW'(CAPTURE_DEPTH)) begin
					mem_we      = accept;
					cap_count_d = cap_count_q + CCW'(1);
				end
			end
			OP_BREAK: begin
				// publish by swapping banks; the capture bank becomes the frame
				if (cap_count_q != '0) begin
					frm_bank_d  = cap_bank_q;
					cap_bank_d  = ~cap_bank_q;
					frm_first_d = first;
					frm_size_d  = (len_full > CCW'(FRAME_SLOTS)) ? SIZE_W'(FRAME_SLOTS)
						: SIZE_W'(len_full);
					frm_count_d = frm_count_q + CNT_W'(1);
					age_d       = '0;
				end
				cap_count_d = '0;
			end
			OP_TICK: begin
				// saturate at the widest timeout, beyond which the link is lost anyway
				if (age_q != '1) begin
					age_d = age_q + TMO_W'(1);
				end
			end
			OP_READ: begin
				mem_re   = accept;
				mem_addr = {frm_bank_q, rd_idx};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stat.packet_size  = frm_size_d;
		stat.packet_count = frm_count_d;
		stat.connected    = enable_q && (age_d < timeout_q);
		stat.read_ok      = (evt.operation == OP_READ) && link_now
			&& (evt.channel != '0)
			&& (evt.channel <= CHAN_W'(CHANNEL_COUNT))
			&& (evt.channel < frm_size_q)
			&& (evt.channel < CHAN_W'(FRAME_SLOTS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			timeout_q   <= TMO_W'(1000);
			cap_count_q <= '0;
			cap_bank_q  <= 1'b0;
			frm_bank_q  <= 1'b1;
			frm_first_q <= 1'b0;
			frm_size_q  <= '0;
			frm_count_q <= '0;
			age_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ENABLE:  enable_q  <= cfg_data[0];
					REG_TIMEOUT: timeout_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept) begin
				cap_count_q <= cap_count_d;
				cap_bank_q  <= cap_bank_d;
				frm_bank_q  <= frm_bank_d;
				frm_first_q <= frm_first_d;
				frm_size_q  <= frm_size_d;
				frm_count_q <= frm_count_d;
				age_q       <= age_d;
			end
		end
	end

endmodule

@@ src/dmx_frame_capture.sv @@
// dmx_frame_capture takes UART events (received byte, break, millisecond tick,
// channel read) as valid/ready beats on evt and answers every event with one
// beat on res that shows the state after it. Bytes are written into one of two
// banks of a single-port synchronous byte memory; a break publishes the capture
// by swapping banks, so no copy is made and the new frame is readable by the
// very next event. The block accepts one event per clock while res is taken;
// each accepted event passes the registered read of the memory and then the
// result register before its beat appears on res. Configuration:
// cfg_we with cfg_index 0 writes receiver_enable (cfg_data bit 0), index 1
// writes timeout_ms. Write configuration only while no event is in flight. No
// clearing pass is needed after reset, the frame size of zero keeps every slot
// unreadable.
module dmx_frame_capture import dmxfc_pkg::*; #(
	parameter int CAPTURE_DEPTH = CAPTURE_DEPTH_DEF,
	parameter int FRAME_SLOTS   = FRAME_SLOTS_DEF,
	parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             evt_valid,
	output logic             evt_ready,
	input  evt_t             evt,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [TMO_W-1:0] cfg_data
);

	localparam int AW = $clog2(CAPTURE_DEPTH) + 1;

	logic              accept;
	logic              advance;
	logic              mem_we;
	logic              mem_re;
	logic [AW-1:0]     mem_addr;
	logic [BYTE_W-1:0] mem_wdata;
	logic [BYTE_W-1:0] mem_rdata;
	stat_t             stat;

	// stage 1 waits for the memory read, the result register parts the sides
	logic  valid_s1;
	stat_t stat_s1;
	logic  res_valid_q;
	res_t  res_q;

	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign evt_ready = !valid_s1 || advance;
	assign accept    = evt_valid && evt_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// event decode, state update and memory requests
	dmxfc_ctrl #(
		.CAPTURE_DEPTH(CAPTURE_DEPTH),
		.FRAME_SLOTS  (FRAME_SLOTS),
		.CHANNEL_COUNT(CHANNEL_COUNT)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.evt      (evt),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.mem_we   (mem_we),
		.mem_re   (mem_re),
		.mem_addr (mem_addr),
		.mem_wdata(mem_wdata),
		.stat     (stat)
	);

	// two capture/frame banks; read data holds while stage 1 is stalled
	dmxfc_mem #(
		.AW(AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stat_s1 <= stat;
		end
		if (advance) begin
			// slot data only on a read that passed every guard
			res_q.read_value   <= stat_s1.read_ok ? mem_rdata : '0;
			res_q.packet_size  <= stat_s1.packet_size;
			res_q.packet_count <= stat_s1.packet_count;
			res_q.connected    <= stat_s1.connected;
		end
	end

endmodule

@@ src/dmxfc_checker.sv @@
module dmxfc_checker import dmxfc_pkg::*; #(
	parameter int FRAME_SLOTS = FRAME_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	// a stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result beat changed while stalled");

	// slot data only while the link is up
	a_read_link: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.connected |-> res.read_value == '0)
		else $error("slot data while link down");

	// nonzero slot data needs a frame with at least one slot past the start code
	a_read_size: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.read_value != '0 |-> res.packet_size > SIZE_W'(1))
		else $error("slot data beyond frame size");

	// a published frame is never empty and never above the slot limit
	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.packet_size <= SIZE_W'(FRAME_SLOTS)
			&& ((res.packet_size == '0) == (res.packet_count == '0)
				|| res.packet_size != '0))
		else $error("packet size out of range");

endmodule

bind dmx_frame_capture dmxfc_checker #(
	.FRAME_SLOTS(FRAME_SLOTS)
) u_dmxfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res      (res)
);

@@ tb/sv/dmx_capture_monitor.sv @@
`timescale 1ns / 1ps

module dmx_capture_monitor import dmxfc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             evt_valid,
	input  logic             evt_ready,
	input  evt_t             evt,
	input  logic             res_valid,
	input  logic             res_ready,
	input  res_t             res,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [TMO_W-1:0] cfg_data,
	output int               mismatches,
	output int               outstanding
);

	localparam int CAP_DEPTH = CAPTURE_DEPTH_DEF;
	localparam int SLOTS     = FRAME_SLOTS_DEF;
	localparam int CHANNELS  = CHANNEL_COUNT_DEF;

	// shadow state of the receiver
	logic [BYTE_W-1:0] capture_bytes [CAP_DEPTH];
	int unsigned       captured;
	logic [BYTE_W-1:0] frame_slots [SLOTS];
	int unsigned       frame_len;
	logic [CNT_W-1:0]  frames_seen;
	logic [31:0]       age;
	logic              enabled;
	logic [TMO_W-1:0]  timeout;

	res_t expected_status [$];
	int   beats_checked;

	function automatic logic link_alive();
		return enabled && (age < 32'(timeout));
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t ns: result beat %0d: %s", $time, beats_checked, msg);
	endtask

	task automatic advance_receiver(input evt_t e, output res_t status);
		int unsigned skip;
		int unsigned len;
		status = '0;
		case (e.operation)
		OP_BYTE: begin
			// bytes past the capture depth are dropped
			if (captured < CAP_DEPTH) begin
				capture_bytes[captured] = e.data_byte;
				captured++;
			end
		end
		OP_BREAK: begin
			if (captured > 0) begin
				skip = (captured >= 2) ? 1 : 0;
				len = captured - skip;
				if (len > SLOTS)
					len = SLOTS;
				for (int i = 0; i < int'(len); i++)
					frame_slots[i] = capture_bytes[i + int'(skip)];
				frame_len = len;
				age = '0;
				frames_seen++;
			end
			captured = 0;
		end
		OP_TICK: begin
			if (age != 32'hFFFF_FFFF)
				age++;
		end
		OP_READ: begin
			if (enabled && link_alive() && e.channel != '0 && int'(e.channel) <= CHANNELS &&
					int'(e.channel) < int'(frame_len) && int'(e.channel) < SLOTS)
				status.read_value = frame_slots[e.channel];
		end
		default: ;
		endcase
		status.packet_size  = SIZE_W'(frame_len);
		status.packet_count = frames_seen;
		status.connected    = link_alive();
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t predicted;
		res_t want;
		if (!arst_n) begin
			captured = 0;
			frame_len = 0;
			frames_seen = '0;
			age = '0;
			enabled = 1'b0;
			timeout = 16'd1000;
			for (int i = 0; i < SLOTS; i++)
				frame_slots[i] = '0;
			expected_status.delete();
			beats_checked = 0;
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_ENABLE:  enabled = cfg_data[0];
				REG_TIMEOUT: timeout = cfg_data;
				default: ;
				endcase
			end
			if (evt_valid && evt_ready) begin
				advance_receiver(evt, predicted);
				expected_status.push_back(predicted);
			end
			if (res_valid && res_ready) begin
				if (expected_status.size() == 0) begin
					report_mismatch("result beat with no event outstanding");
				end else begin
					want = expected_status.pop_front();
					if (res.read_value !== want.read_value)
						report_mismatch($sformatf("read_value %0d, expected %0d",
							res.read_value, want.read_value));
					if (res.packet_size !== want.packet_size)
						report_mismatch($sformatf("packet_size %0d, expected %0d",
							res.packet_size, want.packet_size));
					if (res.packet_count !== want.packet_count)
						report_mismatch($sformatf("packet_count %0d, expected %0d",
							res.packet_count, want.packet_count));
					if (res.connected !== want.connected)
						report_mismatch($sformatf("connected %b, expected %b",
							res.connected, want.connected));
				end
				beats_checked++;
			end
		end
		outstanding = expected_status.size();
	end

endmodule

@@ tb/sv/tb_dmx_frame_capture.sv @@
`timescale 1ns / 1ps

module tb_dmx_frame_capture;
	import dmxfc_pkg::*;

	// generous bound, the slowest clean run stays far below it
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_EVENTS = 700;
	localparam int HOLD_CYCLES   = 400;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             evt_valid = 1'b0;
	logic             evt_ready;
	evt_t             evt = '0;
	logic             res_valid;
	logic             res_ready = 1'b0;
	res_t             res;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = REG_ENABLE;
	logic [TMO_W-1:0] cfg_data = '0;

	int mismatches;
	int outstanding;
	int events_sent = 0;
	int burst_left = 0;
	int cycle_count = 0;
	// asks the receiver for one long hold-off
	bit hold_req = 1'b0;

	always #1 clk = ~clk;

	dmx_frame_capture dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// watches both channels and the config port, predicts and compares
	dmx_capture_monitor monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.evt_valid   (evt_valid),
		.evt_ready   (evt_ready),
		.evt         (evt),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_dmx_frame_capture: done, errors");
			$finish;
		end
	end

	// offer one event beat; bursts of back-to-back beats with random gaps between
	task automatic send_evt(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
			input logic [CHAN_W-1:0] chan);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			if ($urandom_range(0, 2) != 0)
				gap = $urandom_range(1, 5);
		end
		if (gap > 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		// valid and payload held until the beat is taken
		evt_valid <= 1'b1;
		evt <= '{operation: op, data_byte: data, channel: chan};
		do @(posedge clk); while (!evt_ready);
		events_sent++;
	endtask

	// one dmx frame: artifact byte, start code, slots, then the break
	task automatic send_frame(input int n_bytes);
		repeat (n_bytes) send_evt(OP_BYTE, BYTE_W'($urandom), CHAN_W'($urandom));
		send_evt(OP_BREAK, BYTE_W'($urandom), CHAN_W'($urandom));
	endtask

	// read channels mostly around the small frame sizes, some at the top end
	function automatic logic [CHAN_W-1:0] read_channel();
		case ($urandom_range(0, 7))
		0: return CHAN_W'($urandom);
		1: return CHAN_W'($urandom_range(510, 514));
		default: return CHAN_W'($urandom_range(0, 26));
		endcase
	endfunction

	// stop offering and let every outstanding result drain
	task automatic settle();
		evt_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		// memory read and result registers, plus margin
		repeat (4) @(posedge clk);
	endtask

	// both registers, only while idle; junk in the upper enable bits must be ignored
	task automatic write_config(input logic en, input logic [TMO_W-1:0] tmo);
		cfg_we <= 1'b1;
		cfg_index <= REG_ENABLE;
		cfg_data <= (TMO_W'($urandom) & ~TMO_W'(1)) | TMO_W'(en);
		@(posedge clk);
		cfg_index <= REG_TIMEOUT;
		cfg_data <= tmo;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly well-formed frames, ticks and reads, with some noise and stray breaks
	task automatic run_random_phase(input logic en, input logic [TMO_W-1:0] tmo,
			input int n_events);
		int stop_at;
		int pick;
		write_config(en, tmo);
		stop_at = events_sent + n_events;
		while (events_sent < stop_at) begin
			pick = $urandom_range(0, 19);
			if (pick < 7)
				send_frame($urandom_range(0, 24));
			else if (pick < 11)
				repeat ($urandom_range(1, 6))
					send_evt(OP_TICK, BYTE_W'($urandom), CHAN_W'($urandom));
			else if (pick < 17)
				repeat ($urandom_range(1, 6))
					send_evt(OP_READ, BYTE_W'($urandom), read_channel());
			else if (pick < 19)
				send_evt(OP_W'($urandom), BYTE_W'($urandom), CHAN_W'($urandom));
			else
				// back-to-back breaks, the second one finds an empty capture
				repeat (2) send_evt(OP_BREAK, BYTE_W'($urandom), CHAN_W'($urandom));
		end
		settle();
	endtask

	// receiver: stretches of always-ready, coin-flip and mostly-stalled
	initial begin : receiver
		int run_len;
		int style;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				// long hold-off so the pipeline fills and backs up into evt
				hold_req = 1'b0;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			style = $urandom_range(0, 3);
			run_len = $urandom_range(8, 60);
			repeat (run_len) begin
				case (style)
				0, 1: res_ready <= 1'b1;
				2: res_ready <= 1'($urandom_range(0, 1));
				default: res_ready <= ($urandom_range(0, 4) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset config: disabled, reads gated to zero but capture still runs
		send_evt(OP_READ, 8'h00, 10'd1);
		send_evt(OP_BYTE, 8'hAA, 10'd0);
		send_evt(OP_BREAK, 8'h00, 10'd0);
		send_evt(OP_READ, 8'hFF, 10'd0);
		settle();

		write_config(1'b1, 16'hFFFF);
		// empty break publishes nothing
		send_evt(OP_BREAK, 8'h00, 10'd0);
		// artifact byte, start code, two slots
		send_evt(OP_BYTE, 8'h55, 10'd0);
		send_evt(OP_BYTE, 8'h00, 10'd0);
		send_evt(OP_BYTE, 8'hFF, 10'd0);
		send_evt(OP_BYTE, 8'h80, 10'd0);
		send_evt(OP_BREAK, 8'h00, 10'd0);
		send_evt(OP_READ, 8'h00, 10'd1);
		send_evt(OP_READ, 8'h00, 10'd2);
		// at the frame size, start code, and beyond the channel range
		send_evt(OP_READ, 8'h00, 10'd3);
		send_evt(OP_READ, 8'h00, 10'd0);
		send_evt(OP_READ, 8'h00, 10'd1023);
		// single byte makes a one-slot frame, old slots stay unreachable
		send_evt(OP_BYTE, 8'h12, 10'd0);
		send_evt(OP_BREAK, 8'h00, 10'd0);
		send_evt(OP_READ, 8'h00, 10'd1);
		send_evt(OP_READ, 8'h00, 10'd2);
		send_evt(OP_TICK, 8'hFF, 10'h3FF);
		send_evt(OP_TICK, 8'h00, 10'd0);

		// full universe: artifact plus 513 slots, then top channels
		send_frame(514);
		send_evt(OP_READ, 8'h00, 10'd511);
		send_evt(OP_READ, 8'h00, 10'd512);
		send_evt(OP_READ, 8'h00, 10'd513);
		// overrun: capture saturates, frame clamps to 513 slots
		send_frame(CAPTURE_DEPTH_DEF + 6);
		send_evt(OP_READ, 8'h00, 10'd1);
		send_evt(OP_READ, 8'h00, 10'd512);
		settle();

		// short timeouts so the link drops and recovers under ticks
		hold_req = 1'b1;
		run_random_phase(1'b1, 16'd5, RANDOM_EVENTS / 6);
		run_random_phase(1'b1, 16'd1, RANDOM_EVENTS / 6);
		run_random_phase(1'b0, 16'd3, RANDOM_EVENTS / 6);
		// zero timeout, never connected
		run_random_phase(1'b1, 16'd0, RANDOM_EVENTS / 6);
		run_random_phase(1'b1, TMO_W'($urandom_range(2, 40)), RANDOM_EVENTS / 6);
		run_random_phase(1'b1, 16'hFFFF, RANDOM_EVENTS / 6);

		if (mismatches == 0 && outstanding == 0)
			$display("tb_dmx_frame_capture: done, clean");
		else
			$display("tb_dmx_frame_capture: done, errors");
		$finish;
	end

endmodule

@@ files.f @@
src/dmxfc_pkg.sv
src/dmxfc_mem.sv
src/dmxfc_ctrl.sv
src/dmx_frame_capture.sv
src/dmxfc_checker.sv
tb/sv/dmx_capture_monitor.sv
tb/sv/tb_dmx_frame_capture.sv
